// ----- src/ousst_pkg.sv -----
// ----------------------------------------------------------------------------
// ousst_pkg
// Shared types and constants for the ordered unique set table.
// ----------------------------------------------------------------------------
package ousst_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_VALUE_BITS = 32;

    localparam int MODE_BITS   = 3;
    localparam int STATUS_BITS = 2;

    // Operation codes carried on the mode field.
    localparam logic [MODE_BITS-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE   = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_CONTAINS = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_READ     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic eval;       // compare against the held request
        logic add_en;     // append the request value at the fill point
        logic remove_en;  // close the gap left by the matching entry
    } ousst_cell_ctrl_t;

endpackage

// ----- src/ordered_unique_set_table_top.sv -----
// ----------------------------------------------------------------------------
// ordered_unique_set_table_top
// A request is taken only in IDLE and runs in three steps (accept, compare,
// commit), one at a time; the result is loaded into the output register in
// COMMIT, which waits while an earlier result is still stalled at the output.
// Reset: rst_n clears the count, sequencer and output valid; entries are not
// cleared and are only ever read below the count.
// ----------------------------------------------------------------------------
module ordered_unique_set_table_top #(
    parameter int CAPACITY   = ousst_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = ousst_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = $clog2(CAPACITY),
    parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [ousst_pkg::MODE_BITS-1:0]   mode,
    input  logic [VALUE_BITS-1:0]             value,
    input  logic [POS_BITS-1:0]               position,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              found,
    output logic [CNT_BITS-1:0]               count,
    output logic [ousst_pkg::STATUS_BITS-1:0] status,
    output logic [VALUE_BITS-1:0]             read_value
);
    import ousst_pkg::*;

    localparam int LEVELS = $clog2(CAPACITY);

    // The sequencer takes one request at a time. In EVAL every cell compares
    // its entry with the held value in parallel and registers a match bit,
    // while the positional read is gathered from the cells. In COMMIT the
    // match bits decide the update and the result is loaded into the output
    // register, which parts the two channels.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EVAL   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [MODE_BITS-1:0]   mode_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [VALUE_BITS-1:0]  rd_reg;

    logic                   rsp_valid_reg;
    logic                   found_reg;
    logic [CNT_BITS-1:0]    rsp_count_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [VALUE_BITS-1:0]  read_value_reg;

    logic                   req_accept;
    logic                   out_free;
    logic                   commit;
    logic                   hit;
    logic [STATUS_BITS-1:0] status_next;
    logic [VALUE_BITS-1:0]  read_next;
    logic [VALUE_BITS-1:0]  rd_gather;
    ousst_cell_ctrl_t       ctrl;

    logic [VALUE_BITS-1:0]  cell_entry [CAPACITY];
    logic [VALUE_BITS-1:0]  cell_rd    [CAPACITY];
    logic [CAPACITY-1:0]    match_vec;
    logic [LEVELS:0][CAPACITY-1:0] prefix;

    // Only idle takes a new request; a finished result may still sit in the
    // output register while the next request is compared.
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign commit     = (state_reg == ST_COMMIT) && out_free;
    assign hit        = |match_vec;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (req_accept) state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Broadcast controls. An add writes the cell sitting at the fill point;
    // a remove makes every cell at or above the match take its neighbor.
    always_comb
    begin
        ctrl.eval      = (state_reg == ST_EVAL);
        ctrl.add_en    = commit && (mode_reg == MODE_ADD) && !hit &&
                         (count_reg < CNT_BITS'(CAPACITY));
        ctrl.remove_en = commit && (mode_reg == MODE_REMOVE) && hit;
    end

    // Prefix OR of the match bits: bit i is set when the matching entry sits
    // at or below position i. Log-depth so it stays short for any capacity.
    always_comb
    begin
        prefix[0] = match_vec;
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (i >= (1 << l))
                begin
                    prefix[l+1][i] = prefix[l][i] | prefix[l][i - (1 << l)];
                end
                else
                begin
                    prefix[l+1][i] = prefix[l][i];
                end
            end
        end
    end

    // Only the addressed live cell drives a nonzero read word.
    always_comb
    begin
        rd_gather = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_gather = rd_gather | cell_rd[i];
        end
    end

    // Result and new count for the operation in COMMIT.
    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        read_next   = '0;
        case (mode_reg)
            MODE_ADD:
            begin
                if (!hit)
                begin
                    if (count_reg >= CNT_BITS'(CAPACITY))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (hit)
                begin
                    count_next = count_reg - CNT_BITS'(1);
                end
            end
            MODE_CLEAR:
            begin
                count_next = '0;
            end
            MODE_READ:
            begin
                if (CNT_BITS'(pos_reg) < count_reg)
                begin
                    read_next = rd_reg;
                end
                else
                begin
                    status_next = STATUS_RANGE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VALUE_BITS-1:0] upper;
        if (g == CAPACITY - 1)
        begin : g_last
            assign upper = cell_entry[g];
        end
        else
        begin : g_mid
            assign upper = cell_entry[g+1];
        end

        ousst_cell #(
            .INDEX      (g),
            .VALUE_BITS (VALUE_BITS),
            .POS_BITS   (POS_BITS),
            .CNT_BITS   (CNT_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .value       (value_reg),
            .position    (pos_reg),
            .count       (count_reg),
            .upper_entry (upper),
            .shift       (prefix[LEVELS][g]),
            .entry       (cell_entry[g]),
            .match       (match_vec[g]),
            .read_data   (cell_rd[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            mode_reg  <= mode;
            value_reg <= value;
            pos_reg   <= position;
        end
        if (state_reg == ST_EVAL)
        begin
            rd_reg <= rd_gather;
        end
        if (commit)
        begin
            found_reg      <= hit;
            rsp_count_reg  <= count_next;
            status_reg     <= status_next;
            read_value_reg <= read_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign found      = found_reg;
    assign count      = rsp_count_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

endmodule

// ----- src/ousst_cell.sv -----
// ----------------------------------------------------------------------------
// ousst_cell
// One storage cell of the table: holds a single entry, loads it on an add
// at the fill point, compares it with the request value, offers it for a
// positional read and takes the entry above it on a removal at or below it.
// ----------------------------------------------------------------------------
module ousst_cell #(
    parameter int INDEX      = 0,
    parameter int VALUE_BITS = ousst_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = 6,
    parameter int CNT_BITS   = 7
) (
    input  logic                         clk,
    input  ousst_pkg::ousst_cell_ctrl_t  ctrl,
    input  logic [VALUE_BITS-1:0]        value,
    input  logic [POS_BITS-1:0]          position,
    input  logic [CNT_BITS-1:0]          count,
    input  logic [VALUE_BITS-1:0]        upper_entry,
    input  logic                         shift,
    output logic [VALUE_BITS-1:0]        entry,
    output logic                         match,
    output logic [VALUE_BITS-1:0]        read_data
);
    import ousst_pkg::*;

    logic [VALUE_BITS-1:0] entry_reg;
    logic                  match_reg;
    logic                  live;

    assign live = CNT_BITS'(INDEX) < count;

    always_ff @(posedge clk)
    begin
        if (ctrl.eval)
        begin
            match_reg <= live && (entry_reg == value);
        end
        if (ctrl.add_en && (CNT_BITS'(INDEX) == count))
        begin
            entry_reg <= value;
        end
        else if (ctrl.remove_en && shift)
        begin
            entry_reg <= upper_entry;
        end
    end

    assign entry     = entry_reg;
    assign match     = match_reg;
    assign read_data = (live && (POS_BITS'(INDEX) == position)) ? entry_reg : '0;

endmodule

// ----- src/ousst_checker.sv -----
// ----------------------------------------------------------------------------
// ousst_checker
// Port-level checks for the ordered unique set table, bound to the top level.
// ----------------------------------------------------------------------------
module ousst_checker #(
    parameter int CAPACITY   = ousst_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = ousst_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = $clog2(CAPACITY),
    parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_stall,
    input logic [ousst_pkg::MODE_BITS-1:0]   mode,
    input logic [VALUE_BITS-1:0]             value,
    input logic [POS_BITS-1:0]               position,
    input logic                              rsp_valid,
    input logic                              rsp_stall,
    input logic                              found,
    input logic [CNT_BITS-1:0]               count,
    input logic [ousst_pkg::STATUS_BITS-1:0] status,
    input logic [VALUE_BITS-1:0]             read_value
);
    import ousst_pkg::*;

    // A stalled result holds its valid and its fields.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(count) && $stable(status)
            && $stable(found) && $stable(read_value))
        else $error("stalled result changed");

    // The table takes one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count <= CNT_BITS'(CAPACITY))
        else $error("count above capacity");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_FULL |-> count == CNT_BITS'(CAPACITY) && !found)
        else $error("full rejection with room left or value present");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STATUS_RANGE |-> read_value == '0)
        else $error("out-of-range read returned data");

endmodule

bind ordered_unique_set_table_top ousst_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .POS_BITS   (POS_BITS),
    .CNT_BITS   (CNT_BITS)
) u_ousst_checker (.*);

// ----- verif/ordered_unique_set_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_unique_set_table_top_tb
// Self-checking bench for the ordered unique set table. A queue of requests,
// built up front from a directed opener and random sequences, feeds a
// clocked driver. The driver keeps its own model of the stored set and
// predicts each result when its request is accepted. A clocked monitor
// compares every returned result field by field against those predictions.
// ----------------------------------------------------------------------------
module ordered_unique_set_table_top_tb;

    import ousst_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int VALUE_BITS = DEF_VALUE_BITS;
    localparam int POS_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);

    // Mode codes that the block does not define. They must act as no-ops.
    localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

    localparam int TARGET_REQUESTS = 1050;
    localparam int POOL_SIZE       = 80;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode;
        logic [VALUE_BITS-1:0] value;
        logic [POS_BITS-1:0]   position;
    } set_request_t;

    typedef struct packed {
        logic                   found;
        logic [CNT_BITS-1:0]    count;
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  read_value;
    } set_result_t;

    // Every input of the block starts at a known value.
    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   req_valid  = 1'b0;
    logic [MODE_BITS-1:0]   mode       = MODE_CONTAINS;
    logic [VALUE_BITS-1:0]  value      = '0;
    logic [POS_BITS-1:0]    position   = '0;
    logic                   rsp_stall  = 1'b0;
    logic                   req_stall;
    logic                   rsp_valid;
    logic                   found;
    logic [CNT_BITS-1:0]    count;
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  read_value;

    // Requests waiting to be driven and results waiting to come back.
    set_request_t pending_q[$];
    set_result_t  expected_results_q[$];

    // The bench's own copy of the stored set, in insertion order.
    logic [VALUE_BITS-1:0] held[CAPACITY];
    int                    held_count = 0;

    // Values reused by the random part so that hits and removals happen.
    logic [VALUE_BITS-1:0] value_pool[POOL_SIZE];

    int accepted_reqs   = 0;
    int checked_results = 0;
    int mismatches      = 0;
    int full_rejects    = 0;
    int range_misses    = 0;
    int hits            = 0;
    int peak_count      = 0;

    int tx_idle_pct;
    int rx_idle_pct;

    ordered_unique_set_table_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .mode       (mode),
        .value      (value),
        .position   (position),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .found      (found),
        .count      (count),
        .status     (status),
        .read_value (read_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Three stretches of back-pressure: a slow sender with a slower receiver,
    // then the reverse, then both sides running flat out.
    always_comb
    begin
        if (accepted_reqs < TARGET_REQUESTS / 3)
        begin
            tx_idle_pct = 25;
            rx_idle_pct = 55;
        end
        else if (accepted_reqs < (2 * TARGET_REQUESTS) / 3)
        begin
            tx_idle_pct = 55;
            rx_idle_pct = 25;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    // Applies one request to the bench's copy of the set and returns the
    // result the block should give. The membership check always runs on the
    // state before the operation, whatever the mode.
    function automatic set_result_t apply_set_op(set_request_t rq);
        set_result_t r;
        int          slot;
        int          i;
        slot = -1;
        for (i = 0; i < held_count; i++)
        begin
            if (slot < 0 && held[i] == rq.value)
                slot = i;
        end
        r.found      = (slot >= 0);
        r.status     = STATUS_OK;
        r.read_value = '0;
        case (rq.mode)
            MODE_ADD:
            begin
                if (slot < 0)
                begin
                    if (held_count >= CAPACITY)
                        r.status = STATUS_FULL;
                    else
                    begin
                        held[held_count] = rq.value;
                        held_count++;
                    end
                end
            end
            MODE_REMOVE:
            begin
                // Later entries slide down one place so the order is kept.
                if (slot >= 0)
                begin
                    for (i = slot; i + 1 < held_count; i++)
                        held[i] = held[i + 1];
                    held_count--;
                end
            end
            MODE_CLEAR:
                held_count = 0;
            MODE_READ:
            begin
                if (int'(rq.position) < held_count)
                    r.read_value = held[rq.position];
                else
                    r.status = STATUS_RANGE;
            end
            default:
                ;
        endcase
        r.count = CNT_BITS'(held_count);
        return r;
    endfunction

    task automatic queue_request(logic [MODE_BITS-1:0] m, logic [VALUE_BITS-1:0] v,
                                 logic [POS_BITS-1:0] p);
        set_request_t rq;
        rq.mode     = m;
        rq.value    = v;
        rq.position = p;
        pending_q.insert(pending_q.size(), rq);
    endtask

    // A clear, then a run of distinct adds that fills the store, then traffic
    // against the full store: rejected adds, a duplicate add, reads across
    // the whole index range, and removals that reopen room.
    task automatic queue_fill_sequence();
        logic [VALUE_BITS-1:0] fill_vals[$];
        logic [VALUE_BITS-1:0] v;
        bit                    dup;
        int                    k;
        int                    i;
        queue_request(MODE_CLEAR, $urandom, POS_BITS'($urandom_range(0, CAPACITY - 1)));
        while (fill_vals.size() < CAPACITY)
        begin
            v = $urandom;
            dup = 1'b0;
            foreach (fill_vals[j])
                if (fill_vals[j] == v)
                    dup = 1'b1;
            if (!dup)
            begin
                fill_vals.insert(fill_vals.size(), v);
                queue_request(MODE_ADD, v, POS_BITS'($urandom_range(0, CAPACITY - 1)));
            end
        end
        for (i = 0; i < 3; i++)
            queue_request(MODE_ADD, $urandom, POS_BITS'($urandom_range(0, CAPACITY - 1)));
        queue_request(MODE_ADD, fill_vals[$urandom_range(0, CAPACITY - 1)], '0);
        queue_request(MODE_READ, $urandom, POS_BITS'(CAPACITY - 1));
        queue_request(MODE_READ, $urandom, '0);
        for (i = 0; i < 6; i++)
            queue_request(MODE_READ, fill_vals[$urandom_range(0, CAPACITY - 1)],
                          POS_BITS'($urandom_range(0, CAPACITY - 1)));
        queue_request(MODE_CONTAINS, fill_vals[$urandom_range(0, CAPACITY - 1)], '0);
        k = $urandom_range(0, CAPACITY - 1);
        queue_request(MODE_REMOVE, fill_vals[k], '0);
        queue_request(MODE_READ, '0, POS_BITS'(k));
        queue_request(MODE_CONTAINS, fill_vals[k], '0);
        queue_request(MODE_ADD, $urandom, '0);
        queue_request(MODE_ADD, $urandom, '0);
        queue_request(MODE_READ, '0, POS_BITS'(CAPACITY - 1));
        queue_request(MODE_REMOVE, fill_vals[0], '0);
        queue_request(MODE_READ, '0, '0);
    endtask

    // One request drawn mostly from the value pool, with a thin layer of
    // noise: undefined modes and values that were never stored.
    task automatic queue_mixed_request();
        int                    pick;
        logic [VALUE_BITS-1:0] v;
        logic [POS_BITS-1:0]   p;
        pick = $urandom_range(0, 99);
        v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 1))
            p = POS_BITS'($urandom_range(0, CAPACITY - 1));
        else
            p = POS_BITS'($urandom_range(0, 15));
        if (pick < 40)
            queue_request(MODE_ADD, v, p);
        else if (pick < 60)
            queue_request(MODE_REMOVE, v, p);
        else if (pick < 75)
            queue_request(MODE_CONTAINS, v, p);
        else if (pick < 93)
            queue_request(MODE_READ, v, p);
        else if (pick < 95)
            queue_request(MODE_CLEAR, v, p);
        else if (pick < 97)
            queue_request(MODE_BITS'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                          v, p);
        else
            queue_request(MODE_BITS'($urandom_range(0, 7)), $urandom,
                          POS_BITS'($urandom_range(0, CAPACITY - 1)));
    endtask

    // Driver. A request is held steady until the block takes it; the result
    // is predicted at the moment of acceptance, so predictions follow the
    // order in which the block sees the requests.
    always @(posedge clk)
    begin : drive_requests
        set_request_t cur;
        set_request_t nxt;
        bit           take_next;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            take_next = !req_valid;
            if (req_valid && !req_stall)
            begin
                cur.mode     = mode;
                cur.value    = value;
                cur.position = position;
                expected_results_q.insert(expected_results_q.size(), apply_set_op(cur));
                accepted_reqs++;
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    req_valid <= 1'b1;
                    mode      <= nxt.mode;
                    value     <= nxt.value;
                    position  <= nxt.position;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, chosen afresh every cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Monitor. Every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        set_result_t exp_r;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results_q.size() == 0)
            begin
                $display("%0t ERROR result with no request outstanding: expected none,",
                         $time);
                $display("    actual found=%0b count=%0d status=%0d read_value=%h",
                         found, count, status, read_value);
                mismatches++;
            end
            else
            begin
                exp_r = expected_results_q.pop_front();
                checked_results++;
                if (found !== exp_r.found)
                begin
                    $display("%0t ERROR found: expected %0b actual %0b",
                             $time, exp_r.found, found);
                    mismatches++;
                end
                if (count !== exp_r.count)
                begin
                    $display("%0t ERROR count: expected %0d actual %0d",
                             $time, exp_r.count, count);
                    mismatches++;
                end
                if (status !== exp_r.status)
                begin
                    $display("%0t ERROR status: expected %0d actual %0d",
                             $time, exp_r.status, status);
                    mismatches++;
                end
                if (read_value !== exp_r.read_value)
                begin
                    $display("%0t ERROR read_value: expected %h actual %h",
                             $time, exp_r.read_value, read_value);
                    mismatches++;
                end
                if (exp_r.found)
                    hits++;
                if (exp_r.status == STATUS_FULL)
                    full_rejects++;
                if (exp_r.status == STATUS_RANGE)
                    range_misses++;
                if (int'(exp_r.count) > peak_count)
                    peak_count = int'(exp_r.count);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : run_stimulus
        int i;
        int m;

        for (i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        value_pool[0] = '0;
        value_pool[1] = '1;

        // Directed opener: operations on an empty store, both value extremes,
        // a duplicate add, reads at, past and far past the last entry, a
        // removal that shifts the rest down, a removal of an absent value,
        // the undefined modes, and a clear of a populated store.
        queue_request(MODE_READ,     '0,           '0);
        queue_request(MODE_CONTAINS, '0,           '0);
        queue_request(MODE_REMOVE,   '1,           '0);
        queue_request(MODE_ADD,      '0,           '0);
        queue_request(MODE_ADD,      '1,           '0);
        queue_request(MODE_ADD,      '0,           '1);
        queue_request(MODE_ADD,      32'hA5A5A5A5, '0);
        queue_request(MODE_ADD,      32'h5A5A5A5A, '0);
        queue_request(MODE_CONTAINS, '1,           '0);
        queue_request(MODE_READ,     '0,           6'd0);
        queue_request(MODE_READ,     '0,           6'd3);
        queue_request(MODE_READ,     '0,           6'd4);
        queue_request(MODE_READ,     '0,           '1);
        queue_request(MODE_REMOVE,   '0,           '0);
        queue_request(MODE_READ,     '0,           6'd0);
        queue_request(MODE_REMOVE,   32'h12345678, '0);
        for (m = int'(MODE_SPARE_FIRST); m <= int'(MODE_SPARE_LAST); m++)
            queue_request(MODE_BITS'(m), '1, '1);
        queue_request(MODE_CLEAR,    32'hA5A5A5A5, '0);
        queue_request(MODE_READ,     '0,           6'd0);
        queue_request(MODE_CONTAINS, 32'hA5A5A5A5, '0);
        queue_request(MODE_ADD,      32'h80000000, '0);

        // Random part: short mixed bursts over the pool, with an occasional
        // fill-to-capacity sequence so that overflow and the top index get
        // real traffic.
        while (pending_q.size() < TARGET_REQUESTS)
        begin
            if ($urandom_range(0, 14) == 0)
                queue_fill_sequence();
            else
                for (i = 0; i < 20; i++)
                    queue_mixed_request();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last request to be taken and every result to return,
        // then give the block a short while to show any stray result.
        while (pending_q.size() > 0 || req_valid || expected_results_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests, checked %0d results: %0d hits, %0d full rejects,",
                 accepted_reqs, checked_results, hits, full_rejects);
        $display("%0d out-of-range reads, peak occupancy %0d of %0d.",
                 range_misses, peak_count, CAPACITY);
        if (mismatches == 0 && expected_results_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this request count.
    initial
    begin
        #3000000;
        $display("%0t ERROR timeout with %0d requests pending, %0d results outstanding",
                 $time, pending_q.size(), expected_results_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
